[design/lru_ost_pkg.sv]
// ----------------------------------------------------------------------------
// lru_ost_pkg
// Shared constants and types for the LRU open slot tracker.
// ----------------------------------------------------------------------------
package lru_ost_pkg;

  localparam int CAPACITY = 16;
  localparam int NUM_IDS  = 64;
  localparam int ID_W     = $clog2(NUM_IDS);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int LIM_W    = 5;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic CMD_TOUCH  = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [2:0] ADDR_MAX_OPEN = 3'd0;
  localparam logic [LIM_W-1:0] MAX_OPEN_RESET = LIM_W'(CAPACITY);

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } dp_stat_t;

endpackage

[design/lru_ost_ctrl.sv]
// ----------------------------------------------------------------------------
// lru_ost_ctrl
// Sequencer: takes one request, runs the update cycle, holds the result.
// ----------------------------------------------------------------------------
module lru_ost_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  lru_ost_pkg::dp_stat_t stat,
  output lru_ost_pkg::dp_cmd_t  cmd
);
  import lru_ost_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   evict_seen_r;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.exec   = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      evict_seen_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_tready) begin
            out_valid_r <= 1'b0;
          end
          if (cmd.load) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r  <= 1'b1;
          evict_seen_r <= stat.evict && !stat.hit;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  logic unused_evict;
  assign unused_evict = evict_seen_r;

endmodule

[design/lru_ost_dp.sv]
// ----------------------------------------------------------------------------
// lru_ost_dp
// Recency order shift line with parallel id compare and result register.
// ----------------------------------------------------------------------------
module lru_ost_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lru_ost_pkg::dp_cmd_t                   cmd,
  output lru_ost_pkg::dp_stat_t                  stat,
  input  logic [lru_ost_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [lru_ost_pkg::LIM_W-1:0]          max_open,
  output logic [lru_ost_pkg::OUT_DATA_W-1:0]     out_data
);
  import lru_ost_pkg::*;

  logic [ID_W-1:0]  order_r [CAPACITY];
  logic [ID_W-1:0]  order_nxt [CAPACITY];
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             op_r;
  logic [ID_W-1:0]  id_r;

  logic             ev_valid_r;
  logic [ID_W-1:0]  ev_id_r;
  logic [OCC_W-1:0] count_r;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] at_or_above;
  logic [CAPACITY-1:0] at_or_below;
  logic                hit;
  logic                evict;
  logic [OCC_W-1:0]    lim;
  logic [IDX_W-1:0]    last_idx;
  logic [ID_W-1:0]     ev_id;

  always_comb begin
    if (max_open == '0) begin
      lim = OCC_W'(1);
    end else if (OCC_W'(max_open) > OCC_W'(CAPACITY)) begin
      lim = OCC_W'(CAPACITY);
    end else begin
      lim = OCC_W'(max_open);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (OCC_W'(i) < occ_r) && (order_r[i] == id_r);
    end
    at_or_above[CAPACITY-1] = match[CAPACITY-1];
    for (int i = CAPACITY - 2; i >= 0; i--) begin
      at_or_above[i] = at_or_above[i+1] | match[i];
    end
    at_or_below[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      at_or_below[i] = at_or_below[i-1] | match[i];
    end
  end

  assign hit      = |match;
  assign last_idx = IDX_W'(occ_r - OCC_W'(1));
  assign ev_id    = order_r[last_idx];
  assign evict    = (op_r == CMD_TOUCH) && !hit && (occ_r >= lim) && (occ_r != '0);

  assign stat.hit   = hit;
  assign stat.evict = evict;

  always_comb begin
    occ_nxt = occ_r;
    for (int i = 0; i < CAPACITY; i++) begin
      order_nxt[i] = order_r[i];
    end
    if (op_r == CMD_TOUCH) begin
      order_nxt[0] = id_r;
      for (int i = 1; i < CAPACITY; i++) begin
        if (!hit || at_or_above[i]) begin
          order_nxt[i] = order_r[i-1];
        end
      end
      if (!hit && !evict) begin
        occ_nxt = occ_r + OCC_W'(1);
      end
    end else if (hit) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (at_or_below[i]) begin
          order_nxt[i] = order_r[i+1];
        end
      end
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.exec) begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data[0];
      id_r <= in_data[ID_W:1];
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        order_r[i] <= order_nxt[i];
      end
      ev_valid_r <= evict;
      ev_id_r    <= evict ? ev_id : '0;
      count_r    <= occ_nxt;
    end
  end

  assign out_data = {{(OUT_DATA_W - 1 - ID_W - OCC_W){1'b0}}, count_r, ev_id_r, ev_valid_r};

  logic unused_in;
  assign unused_in = ^in_data[IN_DATA_W-1:ID_W+1];
  logic unused_rst;
  assign unused_rst = unused_in & rst_n & 1'b0;

endmodule

[design/lru_open_slot_tracker_top.sv]
// ----------------------------------------------------------------------------
// lru_open_slot_tracker_top
// LRU replacement list over open ids with a programmable open limit.
//
//   channel  direction  fields (lsb first)
//   in_      slave      tdata: command[0], item_id[6:1]
//   out_     master     tdata: evict_valid[0], evicted_id[6:1], open_count[11:7]
//   cfg_     apb        reg 0 max_open at byte address 0
//
// Each request is first captured, then the compare and shift update of the
// sixteen-entry order runs. The next request is taken while a
// result waits, provided the result register is freed by then. Reset
// (rst_n low, synchronous) empties the order and sets max_open to 16.
// ----------------------------------------------------------------------------
module lru_open_slot_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // command, item_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // evict_valid, evicted_id, open_count
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lru_ost_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [LIM_W-1:0] max_open_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_MAX_OPEN) ? {{(32 - LIM_W){1'b0}}, max_open_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_open_r <= MAX_OPEN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_MAX_OPEN) begin
      max_open_r <= cfg_pwdata[LIM_W-1:0];
    end
  end

  lru_ost_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lru_ost_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_tdata),
    .max_open (max_open_r),
    .out_data (out_tdata)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU open slot tracker.
//
// Touch and remove requests go in on the in_ stream. A recency tracker class
// keeps its own copy of the order, the membership flags and the open limit.
// It predicts the eviction and the open count for every accepted request and
// compares each out_ transfer against the oldest prediction. The run has a
// directed part over the limit corner cases and random phases under several
// max_open settings and sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import lru_ost_pkg::*;

  typedef struct packed {
    logic             evict_valid;
    logic [ID_W-1:0]  evicted_id;
    logic [LIM_W-1:0] open_count;
  } slot_result_t;

  class recency_tracker;
    logic [ID_W-1:0]  order [CAPACITY];
    bit               member [NUM_IDS];
    int unsigned      occ;
    logic [LIM_W-1:0] max_open;
    slot_result_t     pending_results [$];
    int               errors;

    function new();
      occ = 0;
      max_open = MAX_OPEN_RESET;
      errors = 0;
      foreach (member[i]) member[i] = 1'b0;
      foreach (order[i]) order[i] = '0;
    endfunction

    function int unsigned locate(logic [ID_W-1:0] id);
      for (int unsigned i = 0; i < occ; i++)
        if (order[i] == id) return i;
      return occ;
    endfunction

    function void apply_request(logic cmd, logic [ID_W-1:0] id);
      int unsigned  limit;
      int unsigned  pos;
      slot_result_t res;
      res = '0;
      limit = (max_open == 0) ? 1 : ((max_open > CAPACITY) ? CAPACITY : max_open);
      if (cmd == CMD_TOUCH) begin
        if (member[id]) begin
          pos = locate(id);
          for (int unsigned i = pos; i > 0; i--) order[i] = order[i-1];
          order[0] = id;
        end else begin
          if (occ >= limit && occ > 0) begin
            res.evict_valid = 1'b1;
            res.evicted_id = order[occ-1];
            member[order[occ-1]] = 1'b0;
            occ--;
          end
          for (int unsigned i = occ; i > 0; i--) order[i] = order[i-1];
          order[0] = id;
          occ++;
          member[id] = 1'b1;
        end
      end else if (member[id]) begin
        pos = locate(id);
        for (int unsigned i = pos; i + 1 < occ; i++) order[i] = order[i+1];
        occ--;
        member[id] = 1'b0;
      end
      res.open_count = occ[LIM_W-1:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      slot_result_t got;
      slot_result_t exp_r;
      got.evict_valid = data[0];
      got.evicted_id = data[ID_W:1];
      got.open_count = data[ID_W+LIM_W:ID_W+1];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual ev=%0d id=%0d cnt=%0d", $time,
                 got.evict_valid, got.evicted_id, got.open_count);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.evict_valid !== exp_r.evict_valid) begin
        $display("%0t: evict_valid expected %0d actual %0d", $time,
                 exp_r.evict_valid, got.evict_valid);
        errors++;
      end
      if (got.evicted_id !== exp_r.evicted_id) begin
        $display("%0t: evicted_id expected %0d actual %0d", $time,
                 exp_r.evicted_id, got.evicted_id);
        errors++;
      end
      if (got.open_count !== exp_r.open_count) begin
        $display("%0t: open_count expected %0d actual %0d", $time,
                 exp_r.open_count, got.open_count);
        errors++;
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // command, item_id
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // evict_valid, evicted_id, open_count
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   quiet_cycles;
  recency_tracker tracker;

  lru_open_slot_tracker_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 tracker.pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // starts and ends at a falling edge; valid stays high for the next request
  task send_request(input logic cmd, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, id, cmd};
    do @(posedge clk); while (!in_tready);
    tracker.apply_request(cmd, id);
    @(negedge clk);
  endtask

  task drain_results;
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task write_max_open(input logic [31:0] value);
    drain_results();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_MAX_OPEN;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.max_open = value[LIM_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  initial begin
    logic [31:0]     settings [8];
    int unsigned     limit;
    int unsigned     pool;
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] id;
    logic            cmd;

    tracker = new();
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: front touch, move to front, remove of absent id
    send_request(CMD_TOUCH, 6'd0);
    send_request(CMD_TOUCH, 6'd63);
    send_request(CMD_TOUCH, 6'd0);
    send_request(CMD_TOUCH, 6'd0);
    send_request(CMD_REMOVE, 6'd42);
    send_request(CMD_REMOVE, 6'd63);
    send_request(CMD_REMOVE, 6'd0);

    // limit of one, then zero taken as one
    write_max_open(32'd1);
    send_request(CMD_TOUCH, 6'd21);
    send_request(CMD_TOUCH, 6'd42);
    send_request(CMD_REMOVE, 6'd42);
    write_max_open(32'd0);
    send_request(CMD_TOUCH, 6'd1);
    send_request(CMD_TOUCH, 6'd62);

    // limit above capacity saturates; fill, evict, then lower the limit
    write_max_open(32'd31);
    for (int i = 0; i < 16; i++) send_request(CMD_TOUCH, ID_W'(i * 4 + 3));
    send_request(CMD_TOUCH, 6'd60);
    write_max_open(32'hFFFF_FFE3);
    send_request(CMD_TOUCH, 6'd61);
    send_request(CMD_TOUCH, 6'd60);

    settings[0] = 32'd16;
    settings[1] = 32'd2;
    settings[2] = 32'd4;
    settings[3] = 32'd31;
    settings[4] = 32'd0;
    settings[5] = 32'hFFFF_FFE8;
    settings[6] = 32'd1;
    settings[7] = 32'd12;

    for (int seg = 0; seg < 8; seg++) begin
      write_max_open(settings[seg]);
      limit = (settings[seg][4:0] == 0) ? 1 :
              ((settings[seg][4:0] > CAPACITY) ? CAPACITY : settings[seg][4:0]);
      pool = limit + 3;
      base = ID_W'($urandom_range(63));
      case (seg % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 53;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 53;
        end
        default: begin
          idle_pct = 6;
          stall_pct = 6;
        end
      endcase
      for (int n = 0; n < 94; n++) begin
        // hold off until every predicted result has come back
        if (seg == 0 && n == 47) drain_results();
        cmd = ($urandom_range(99) < 30) ? CMD_REMOVE : CMD_TOUCH;
        if ($urandom_range(99) < 75)
          id = base + ID_W'($urandom_range(pool - 1));
        else
          id = ID_W'($urandom_range(63));
        send_request(cmd, id);
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    drain_results();
    repeat (10) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/lru_ost_pkg.sv
design/lru_ost_ctrl.sv
design/lru_ost_dp.sv
design/lru_open_slot_tracker_top.sv
tb/tb_top.sv
